// File: rtl/ros_pkg.sv
// Shared types and constants for the ray / sphere occlusion test.
`default_nettype none
package ros_pkg;

  // Field widths of the ray and configuration beats.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned DirW    = 18;
  localparam int unsigned RadiusW = 31;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned FracBits = 16;

  // The square root retires two result bits per pipeline stage.
  localparam int unsigned SqrtSteps     = 32;
  localparam int unsigned SqrtPerStage  = 2;
  localparam int unsigned SqrtStages    = SqrtSteps / SqrtPerStage;
  localparam int unsigned RadW          = 62;
  localparam int unsigned RootW         = 31;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X = 8'd0,
    CFG_CENTER_Y = 8'd1,
    CFG_CENTER_Z = 8'd2,
    CFG_RADIUS   = 8'd3
  } cfg_idx_e;

endpackage
`default_nettype wire

// File: rtl/ros_if.sv
// Channel interfaces for rays, results and configuration writes.
`default_nettype none
interface ros_ray_if;
  logic                              valid;
  logic                              ready;
  logic signed [ros_pkg::CoordW-1:0] origin_x;
  logic signed [ros_pkg::CoordW-1:0] origin_y;
  logic signed [ros_pkg::CoordW-1:0] origin_z;
  logic signed [ros_pkg::DirW-1:0]   dir_x;
  logic signed [ros_pkg::DirW-1:0]   dir_y;
  logic signed [ros_pkg::DirW-1:0]   dir_z;
  logic signed [ros_pkg::CoordW-1:0] max_distance;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  max_distance, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                max_distance, output ready);
endinterface

interface ros_res_if;
  logic valid;
  logic ready;
  logic occluded;
  modport source (output valid, occluded, input ready);
  modport sink (input valid, occluded, output ready);
endinterface

interface ros_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ros_pkg::CfgIdxW-1:0]        idx;
  logic [ros_pkg::CoordW-1:0]         wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface
`default_nettype wire

// File: rtl/ray_sphere_occlusion_test.sv
// Top level of the ray / sphere occlusion test pipeline.
// Stages: 7 arithmetic stages, 16 square-root stages, 1 output register.
// Throughput: one ray per cycle while no result beat waits.
// The whole pipeline advances together and holds while a result beat waits.
// Reset clears all valid bits and loads center 0 and radius 1.0; no clearing pass.
`default_nettype none
module ray_sphere_occlusion_test (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ros_ray_if.sink    ray_i,
  ros_res_if.source  res_o,
  ros_cfg_if.sink    cfg_i
);

  localparam int unsigned SideW = 37 + 32 + 2;

  // Configuration registers.
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        rad_q;
  logic [61:0]        r2_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= 31'd65536;
    end else if (cfg_i.valid) begin
      unique case (ros_pkg::cfg_idx_e'(cfg_i.idx))
        ros_pkg::CFG_CENTER_X: cx_q  <= cfg_i.wdata;
        ros_pkg::CFG_CENTER_Y: cy_q  <= cfg_i.wdata;
        ros_pkg::CFG_CENTER_Z: cz_q  <= cfg_i.wdata;
        ros_pkg::CFG_RADIUS:   rad_q <= cfg_i.wdata[30:0];
        default: ;
      endcase
    end
  end

  // Radius squared, refreshed every cycle from the radius register.
  always_ff @(posedge clk_i) begin
    r2_q <= rad_q * rad_q;
  end

  // Global advance: every stage moves unless a result beat is stuck.
  logic adv;
  logic out_valid_q, occ_q;
  assign adv         = !out_valid_q || res_o.ready;
  assign ray_i.ready = adv;

  logic [6:0] v_q;

  // Stage 1: center minus origin.
  logic signed [32:0] d1_q [3];
  logic signed [17:0] dir1_q [3];
  logic signed [31:0] maxd1_q;

  // Stage 2: squares of |d| and d * dir products.
  logic signed [32:0] d2_q [3];
  logic signed [17:0] dir2_q [3];
  logic signed [31:0] maxd2_q;
  logic [61:0]        sq2_q [3];
  logic               sat2_q;
  logic signed [50:0] pr2_q [3];

  // Stage 3: |d|^2 test and floored dot product.
  logic signed [32:0] d3_q [3];
  logic signed [17:0] dir3_q [3];
  logic signed [31:0] maxd3_q;
  logic               in3_q, neg3_q;
  logic signed [36:0] dot3_q;

  // Stage 4: dir * dot.
  logic signed [32:0] d4_q [3];
  logic signed [31:0] maxd4_q;
  logic               in4_q, neg4_q;
  logic signed [36:0] dot4_q;
  logic signed [54:0] p4_q [3];

  // Stage 5: projected offset magnitudes.
  logic signed [31:0] maxd5_q;
  logic               in5_q, neg5_q, sat5_q;
  logic signed [36:0] dot5_q;
  logic [30:0]        em5_q [3];

  // Stage 6: offset squares.
  logic signed [31:0] maxd6_q;
  logic               in6_q, neg6_q, sat6_q;
  logic signed [36:0] dot6_q;
  logic [61:0]        esq6_q [3];

  // Stage 7: e^2 test and square-root operand.
  logic signed [31:0] maxd7_q;
  logic               known7_q, kval7_q;
  logic signed [36:0] dot7_q;
  logic [61:0]        rem7_q;

  // Combinational values per stage.
  logic signed [32:0] d1_d [3];
  logic [32:0]        md2 [3];
  logic [63:0]        d2sum;
  logic signed [52:0] dotf;
  logic signed [39:0] e5 [3];
  logic [39:0]        em5 [3];
  logic [63:0]        e2sum;
  logic               outside7;

  always_comb begin
    d1_d[0] = {cx_q[31], cx_q} - {ray_i.origin_x[31], ray_i.origin_x};
    d1_d[1] = {cy_q[31], cy_q} - {ray_i.origin_y[31], ray_i.origin_y};
    d1_d[2] = {cz_q[31], cz_q} - {ray_i.origin_z[31], ray_i.origin_z};
    for (int i = 0; i < 3; i++) begin
      md2[i] = d1_q[i][32] ? 33'(-d1_q[i]) : 33'(d1_q[i]);
      e5[i]  = 40'($signed(p4_q[i][54:16])) - 40'(d4_q[i]);
      em5[i] = e5[i][39] ? 40'(-e5[i]) : 40'(e5[i]);
    end
    d2sum = sat2_q ? '1 : 64'(sq2_q[0]) + 64'(sq2_q[1]) + 64'(sq2_q[2]);
    dotf  = 53'(pr2_q[0]) + 53'(pr2_q[1]) + 53'(pr2_q[2]);
    e2sum = sat6_q ? '1 : 64'(esq6_q[0]) + 64'(esq6_q[1]) + 64'(esq6_q[2]);
    outside7 = e2sum > 64'(r2_q);
  end

  // Payload registers of the arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q    <= d1_d;
      dir1_q[0] <= ray_i.dir_x;
      dir1_q[1] <= ray_i.dir_y;
      dir1_q[2] <= ray_i.dir_z;
      maxd1_q <= ray_i.max_distance;

      d2_q    <= d1_q;
      dir2_q  <= dir1_q;
      maxd2_q <= maxd1_q;
      sat2_q  <= |{md2[0][32:31], md2[1][32:31], md2[2][32:31]};
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= md2[i][30:0] * md2[i][30:0];
        pr2_q[i] <= d1_q[i] * dir1_q[i];
      end

      d3_q    <= d2_q;
      dir3_q  <= dir2_q;
      maxd3_q <= maxd2_q;
      in3_q   <= d2sum < 64'(r2_q);
      neg3_q  <= dotf[52];
      dot3_q  <= dotf[52:16];

      d4_q    <= d3_q;
      maxd4_q <= maxd3_q;
      in4_q   <= in3_q;
      neg4_q  <= neg3_q;
      dot4_q  <= dot3_q;
      for (int i = 0; i < 3; i++) begin
        p4_q[i] <= dir3_q[i] * dot3_q;
      end

      maxd5_q <= maxd4_q;
      in5_q   <= in4_q;
      neg5_q  <= neg4_q;
      dot5_q  <= dot4_q;
      sat5_q  <= |{em5[0][39:31], em5[1][39:31], em5[2][39:31]};
      for (int i = 0; i < 3; i++) begin
        em5_q[i] <= em5[i][30:0];
      end

      maxd6_q <= maxd5_q;
      in6_q   <= in5_q;
      neg6_q  <= neg5_q;
      dot6_q  <= dot5_q;
      sat6_q  <= sat5_q;
      for (int i = 0; i < 3; i++) begin
        esq6_q[i] <= em5_q[i] * em5_q[i];
      end

      maxd7_q  <= maxd6_q;
      dot7_q   <= dot6_q;
      known7_q <= in6_q || neg6_q || outside7;
      kval7_q  <= in6_q;
      rem7_q   <= 62'(64'(r2_q) - e2sum);
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[5:0], ray_i.valid};
    end
  end

  // Chord half-length.
  logic              sq_valid;
  logic [30:0]       half;
  logic [SideW-1:0]  sq_side;

  ros_isqrt #(
    .SideW (SideW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_q[6]),
    .rad_i   (rem7_q),
    .side_i  ({dot7_q, maxd7_q, known7_q, kval7_q}),
    .valid_o (sq_valid),
    .root_o  (half),
    .side_o  (sq_side)
  );

  // Hit distance against the limit.
  logic signed [36:0] dot_f;
  logic signed [31:0] maxd_f;
  logic               known_f, kval_f;
  logic signed [38:0] t_f;
  logic               hit_f;

  always_comb begin
    {dot_f, maxd_f, known_f, kval_f} = sq_side;
    t_f   = 39'(dot_f) - $signed({8'd0, half});
    hit_f = known_f ? kval_f : (t_f <= 39'(maxd_f));
  end

  // Output register for the result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      occ_q <= hit_f;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.occluded = occ_q;

endmodule
`default_nettype wire

// File: rtl/ros_isqrt.sv
// Pipelined integer square root, two result bits per stage, with sideband.
`default_nettype none
module ros_isqrt #(
  parameter int unsigned SideW = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [ros_pkg::RadW-1:0]  rad_i,
  input  wire logic [SideW-1:0]          side_i,
  output logic                           valid_o,
  output logic [ros_pkg::RootW-1:0]      root_o,
  output logic [SideW-1:0]               side_o
);

  localparam int unsigned Stages = ros_pkg::SqrtStages;

  logic [62:0]      n_q [Stages];
  logic [62:0]      r_q [Stages];
  logic [62:0]      n_d [Stages];
  logic [62:0]      r_d [Stages];
  logic [SideW-1:0] side_q [Stages];
  logic [Stages-1:0] valid_q;

  // Each stage runs two restoring steps on its own remainder and root.
  always_comb begin
    logic [62:0] nn;
    logic [62:0] rr;
    logic [62:0] b;
    for (int g = 0; g < Stages; g++) begin
      nn = (g == 0) ? {1'b0, rad_i} : n_q[(g == 0) ? 0 : g - 1];
      rr = (g == 0) ? 63'd0 : r_q[(g == 0) ? 0 : g - 1];
      for (int j = 0; j < ros_pkg::SqrtPerStage; j++) begin
        b = 63'd1 << (62 - 2 * (ros_pkg::SqrtPerStage * g + j));
        if (nn >= rr + b) begin
          nn = nn - (rr + b);
          rr = (rr >> 1) + b;
        end else begin
          rr = rr >> 1;
        end
      end
      n_d[g] = nn;
      r_d[g] = rr;
    end
  end

  // Stage registers for the arithmetic and the sideband.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < Stages; g++) begin
        n_q[g]    <= n_d[g];
        r_q[g]    <= r_d[g];
        side_q[g] <= (g == 0) ? side_i : side_q[(g == 0) ? 0 : g - 1];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Stages-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign root_o  = r_q[Stages-1][ros_pkg::RootW-1:0];
  assign side_o  = side_q[Stages-1];

endmodule
`default_nettype wire

// File: rtl/ros_checker.sv
// Port-level assertions for the occlusion test, bound to the top level.
`default_nettype none
module ros_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_occluded_i,
  input wire logic cfg_ready_i
);

  // A waiting result beat stays and holds its flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_occluded_i))
    else $error("result beat dropped or changed while stalled");

  // A stuck result stalls the ray side.
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("ray accepted while the pipeline is stalled");

  // With no result waiting the pipeline takes a ray.
  a_free_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("ray side not ready while output is free");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind ray_sphere_occlusion_test ros_checker u_ros_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (ray_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_occluded_i (res_o.occluded),
  .cfg_ready_i    (cfg_i.ready)
);
`default_nettype wire

// File: tb/ros_tb_if.sv
// Testbench constants shared by the test files.
`timescale 1ns / 1ps
`default_nettype none
package ros_tb_pkg;
  // Depth from an accepted ray to its result beat when the output never stalls.
  localparam int unsigned PipeLatency = 24;
endpackage
`default_nettype wire

// File: tb/ray_sphere_occlusion_test_test.sv
// Self-checking testbench for the ray / sphere occlusion test pipeline.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_occlusion_test_test;

  localparam int unsigned CoordW   = ros_pkg::CoordW;
  localparam int unsigned DirW     = ros_pkg::DirW;
  localparam int unsigned RadiusW  = ros_pkg::RadiusW;
  localparam int unsigned CfgIdxW  = ros_pkg::CfgIdxW;
  localparam int unsigned FracBits = ros_pkg::FracBits;

  // An index past the last register; writes to it are ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 8'd9;

  typedef struct {
    logic signed [CoordW-1:0] ox, oy, oz;
    logic signed [DirW-1:0]   dx, dy, dz;
    logic signed [CoordW-1:0] maxd;
  } ray_t;

  typedef struct {
    logic [CfgIdxW-1:0] idx;
    logic [CoordW-1:0]  wdata;
  } cfg_t;

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  bit stall_free;
  bit cfg_done;
  bit ray_taken;
  bit cfg_taken;

  ros_ray_if ray_if ();
  ros_res_if res_if ();
  ros_cfg_if cfg_if ();

  ray_sphere_occlusion_test i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ray_i  (ray_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // Sphere state as the predictor sees it.
  logic signed [CoordW-1:0] sph_cx, sph_cy, sph_cz;
  logic [RadiusW-1:0]       sph_r;

  ray_t ray_pending[$];
  bit   occl_expected[$];
  cfg_t cfg_pending[$];

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Saturating sum of squares of three Q16.16 values, Q32.32 result.
  function automatic logic [63:0] sq_sum3(input longint v0, input longint v1,
                                          input longint v2);
    longint vals[3];
    logic [63:0] acc;
    logic [63:0] a;
    vals[0] = v0;
    vals[1] = v1;
    vals[2] = v2;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      a = (vals[i] < 0) ? -vals[i] : vals[i];
      if (a >= 64'h8000_0000) return '1;
      acc += a * a;
    end
    return acc;
  endfunction

  // Integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Predict the occluded flag for one ray against the current sphere.
  function automatic bit predict_occluded(input ray_t r);
    longint d[3], dir[3], e[3];
    longint dot_full, dot_q, t;
    logic [63:0] r2, d2, e2, half;
    r2 = {33'd0, sph_r} * {33'd0, sph_r};
    d[0] = longint'(sph_cx) - longint'(r.ox);
    d[1] = longint'(sph_cy) - longint'(r.oy);
    d[2] = longint'(sph_cz) - longint'(r.oz);
    dir[0] = longint'(r.dx);
    dir[1] = longint'(r.dy);
    dir[2] = longint'(r.dz);
    d2 = sq_sum3(d[0], d[1], d[2]);
    if (d2 < r2) return 1'b1;
    dot_full = d[0] * dir[0] + d[1] * dir[1] + d[2] * dir[2];
    if (dot_full < 0) return 1'b0;
    dot_q = dot_full >>> FracBits;
    for (int i = 0; i < 3; i++) e[i] = ((dir[i] * dot_q) >>> FracBits) - d[i];
    e2 = sq_sum3(e[0], e[1], e[2]);
    if (e2 > r2) return 1'b0;
    half = floor_sqrt(r2 - e2);
    t = dot_q - longint'(half);
    return t <= longint'(r.maxd);
  endfunction

  // Update predictor registers on a configuration write.
  function automatic void apply_cfg(input cfg_t c);
    case (c.idx)
      ros_pkg::CFG_CENTER_X: sph_cx = c.wdata;
      ros_pkg::CFG_CENTER_Y: sph_cy = c.wdata;
      ros_pkg::CFG_CENTER_Z: sph_cz = c.wdata;
      ros_pkg::CFG_RADIUS:   sph_r  = c.wdata[RadiusW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [DirW-1:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 18'sh10000;
      1: return -18'sh10000;
      2: return 18'sh0;
      3: return DirW'($urandom_range(0, 18'h3ffff));
      default: return DirW'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Ray aimed near the sphere so that hits and misses are both common.
  function automatic ray_t aimed_ray();
    ray_t r;
    int unsigned span;
    span = $urandom_range(1, 20) << 16;
    r.ox = sph_cx + $signed($urandom_range(0, 2 * span)) - $signed(span);
    r.oy = sph_cy + $signed($urandom_range(0, 2 * span)) - $signed(span);
    r.oz = sph_cz - $signed(span);
    r.dx = DirW'($signed($urandom_range(0, 16384)) - 8192);
    r.dy = DirW'($signed($urandom_range(0, 16384)) - 8192);
    r.dz = 18'sh0fc00;
    r.maxd = $urandom_range(0, 1) ? $signed($urandom_range(0, 40 << 16)) : $urandom;
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.ox = $urandom;
    r.oy = $urandom;
    r.oz = $urandom;
    r.dx = rand_dir();
    r.dy = rand_dir();
    r.dz = rand_dir();
    r.maxd = $urandom;
    return r;
  endfunction

  // Ray driver: holds a waiting beat, or starts the next one at the falling edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_if.valid <= 1'b0;
    end else if (ray_if.valid && !ray_taken) begin
      ray_if.valid <= 1'b1;
    end else if (ray_pending.size() != 0 &&
                 (stall_free || $urandom_range(0, 99) >= 32)) begin
      ray_if.valid        <= 1'b1;
      ray_if.origin_x     <= ray_pending[0].ox;
      ray_if.origin_y     <= ray_pending[0].oy;
      ray_if.origin_z     <= ray_pending[0].oz;
      ray_if.dir_x        <= ray_pending[0].dx;
      ray_if.dir_y        <= ray_pending[0].dy;
      ray_if.dir_z        <= ray_pending[0].dz;
      ray_if.max_distance <= ray_pending[0].maxd;
    end else begin
      ray_if.valid <= 1'b0;
    end
  end

  // Result sink readiness, random stalls at the falling edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= stall_free || $urandom_range(0, 99) >= 32;
    end
  end

  // Configuration driver.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
    end else if (cfg_if.valid && !cfg_taken) begin
      cfg_if.valid <= 1'b1;
    end else if (cfg_pending.size() != 0) begin
      cfg_if.valid <= 1'b1;
      cfg_if.idx   <= cfg_pending[0].idx;
      cfg_if.wdata <= cfg_pending[0].wdata;
    end else begin
      cfg_if.valid <= 1'b0;
    end
  end

  // Monitor: predict on accepted rays and configuration beats, check results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      cfg_taken = cfg_if.valid && cfg_if.ready;
      ray_taken = ray_if.valid && ray_if.ready;
      if (cfg_taken) begin
        apply_cfg(cfg_pending[0]);
        void'(cfg_pending.pop_front());
      end
      if (ray_taken) begin
        occl_expected.push_back(predict_occluded(ray_pending[0]));
        void'(ray_pending.pop_front());
      end
      if (res_if.valid && res_if.ready) begin
        if (occl_expected.size() == 0) begin
          $error("occluded: unexpected result beat, actual %0b", res_if.occluded);
          err_cnt++;
        end else begin
          if (res_if.occluded !== occl_expected[0]) begin
            $error("occluded: expected %0b actual %0b", occl_expected[0], res_if.occluded);
            err_cnt++;
          end
          void'(occl_expected.pop_front());
        end
      end
    end
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    if (cycle_cnt > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    while (ray_pending.size() || occl_expected.size() || cfg_pending.size())
      @(posedge clk_i);
    repeat (ros_tb_pkg::PipeLatency + 4) @(posedge clk_i);
  endtask

  task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] r);
    cfg_pending.push_back('{ros_pkg::CFG_CENTER_X, cx});
    cfg_pending.push_back('{ros_pkg::CFG_CENTER_Y, cy});
    cfg_pending.push_back('{ros_pkg::CFG_CENTER_Z, cz});
    cfg_pending.push_back('{ros_pkg::CFG_RADIUS, r});
    cfg_pending.push_back('{CfgIdxSpare, $urandom});
    while (cfg_pending.size()) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Stimulus sequence.
  initial begin
    ray_t r;
    rst_ni = 1'b0;
    cycle_cnt = 0;
    err_cnt = 0;
    stall_free = 1'b0;
    ray_taken = 1'b0;
    cfg_taken = 1'b0;
    sph_cx = '0;
    sph_cy = '0;
    sph_cz = '0;
    sph_r = 31'd65536;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rays against the reset sphere.
    ray_pending.push_back('{0, 0, 0, 18'sh10000, 0, 0, 0});
    ray_pending.push_back('{32'sh10000, 0, 0, 0, 0, 18'sh10000, 0});
    ray_pending.push_back('{-32'sh50000, 0, 0, 18'sh10000, 0, 0, 32'sh7fffffff});
    ray_pending.push_back('{-32'sh50000, 0, 0, -18'sh10000, 0, 0, 32'sh7fffffff});
    ray_pending.push_back('{-32'sh50000, 32'sh10000, 0, 18'sh10000, 0, 0, 32'sh7fffffff});
    ray_pending.push_back('{-32'sh50000, 32'sh20000, 0, 18'sh10000, 0, 0, 32'sh7fffffff});
    ray_pending.push_back('{-32'sh50000, 0, 0, 18'sh10000, 0, 0, 32'sh30000});
    ray_pending.push_back('{-32'sh50000, 0, 0, 18'sh10000, 0, 0, -32'sh10000});
    ray_pending.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                            -18'sh20000, 18'sh1ffff, -18'sh20000, 32'sh80000000});
    ray_pending.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                            18'sh1ffff, -18'sh20000, 18'sh1ffff, 32'sh7fffffff});
    wait_drained();

    // Zero radius, then extremes of the sphere.
    set_sphere(32'sh30000, -32'sh20000, 0, 0);
    ray_pending.push_back('{0, -32'sh20000, 0, 18'sh10000, 0, 0, 32'sh7fffffff});
    ray_pending.push_back('{32'sh30000, -32'sh20000, 0, 18'sh10000, 0, 0, 0});
    ray_pending.push_back('{0, -32'sh10000, 0, 18'sh10000, 0, 0, 32'sh7fffffff});
    wait_drained();
    set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    ray_pending.push_back('{0, 0, 0, 18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 0});
    ray_pending.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                            18'sh10000, -18'sh10000, 18'sh10000, 32'sh7fffffff});
    wait_drained();

    // Random phases over several sphere settings.
    for (int ph = 0; ph < 4; ph++) begin
      set_sphere($urandom_range(0, 1) ? $urandom : ($urandom_range(0, 64) << 16) - (32 << 16),
                 ($urandom_range(0, 64) << 16) - (32 << 16), $urandom,
                 ph == 3 ? $urandom : $urandom_range(0, 8 << 16));
      stall_free = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        r = ($urandom_range(0, 99) < 75) ? aimed_ray() : noise_ray();
        ray_pending.push_back(r);
        if (n == 50) begin
          // Hold the sender until everything in flight has returned.
          while (ray_pending.size() || occl_expected.size()) @(posedge clk_i);
        end
        while (ray_pending.size() > 8) @(posedge clk_i);
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
